[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Assertion on the usual clk_i / rst_ni pair.
`define ASSERT_DFLT(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/csfw_pkg.sv]
// ----------------------------------------------------------------------------
// Semaphore package
// Request/status codes and field layout of the semaphore streams.
// ----------------------------------------------------------------------------
package csfw_pkg;

  typedef enum logic [1:0] {
    ACT_DOWN    = 2'd0,
    ACT_UP      = 2'd1,
    ACT_DESTROY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_WOKEN     = 3'd2,
    ST_NO_WAITER = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  localparam int unsigned TaskW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned InitW   = 15;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic signed [CountW-1:0] CountCeil = 16'sd32767;

  // Register map: only bit 2 of the byte address selects a word
  localparam logic RegInitialCount = 1'b0;

endpackage

[hw/rtl/counting_semaphore_fifo_waiters.sv]
// ----------------------------------------------------------------------------
// Counting semaphore with FIFO wait queue
// Down/up/destroy requests in, one or more status results out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (action, task id) and results leave
//   on m_axis (status, task id, tlast on the final result of a request).
//   initial_count is written over the APB port at address 0; it takes effect
//   at reset-free reload points (destroy), not on the running count.
// Sequencing / throughput:
//   Down and up without a waiter: result registered in the cycle after the
//   request, a new request every cycle while the receiver keeps up.
//   Up that wakes a waiter: the queue memory read is registered, then the
//   result is registered from it in S_WAKE; no request is taken meanwhile.
//   Destroy with N waiters: one waiter per cycle while the receiver keeps up,
//   through the single read port of the queue memory; none if queue is empty.
// Reset:
//   Count, pointers and waiter total clear; queue contents are left as is.
// Stall:
//   A stalled result holds on m_axis; the block takes a new request only
//   when the output register is free or being drained, and a destroy sweep
//   pauses until the receiver takes each release.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [csfw_pkg::InDataW-1:0]      s_axis_tdata,  // action[1:0], task_id[9:2]
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [csfw_pkg::OutDataW-1:0]     m_axis_tdata,  // status[2:0], task_id_out[10:3]
  output logic                              m_axis_tlast,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csfw_pkg::AddrW-1:0]        paddr,
  input  logic [csfw_pkg::ApbDataW-1:0]     pwdata,
  output logic [csfw_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  import csfw_pkg::*;

  localparam int unsigned PtrW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned TotW = $clog2(MAX_WAITERS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAKE,
    S_DRAIN
  } state_e;

  state_e                    state_q, state_d;
  logic signed [CountW-1:0]  count_q, count_d;
  logic [PtrW-1:0]           head_q, head_d;
  logic [PtrW-1:0]           tail_q, tail_d;
  logic [TotW-1:0]           total_q, total_d;
  logic [InitW-1:0]          init_q;
  logic                      out_valid_q, out_valid_d;
  status_e                   out_status_q, out_status_d;
  logic [TaskW-1:0]          out_tid_q, out_tid_d;
  logic                      out_last_q, out_last_d;

  logic                      out_free;
  logic                      in_accept;
  action_e                   in_action;
  logic [TaskW-1:0]          in_tid;
  logic signed [CountW-1:0]  count_inc;
  logic signed [CountW-1:0]  count_init;
  logic                      cfg_write;

  logic                      ram_we;
  logic                      ram_re;
  logic [TaskW-1:0]          ram_rdata;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(MAX_WAITERS - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegInitialCount);
  assign prdata    = (paddr[2] == RegInitialCount) ?
                     {{(ApbDataW - InitW){1'b0}}, init_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cfg_write) begin
      init_q <= pwdata[InitW-1:0];
    end
  end

  // ---------------------------------------------------------------- datapath
  assign in_action  = action_e'(s_axis_tdata[1:0]);
  assign in_tid     = s_axis_tdata[2 +: TaskW];
  assign out_free   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign count_inc  = (count_q < CountCeil) ? count_q + 16'sd1 : count_q;
  assign count_init = signed'({1'b0, init_q});

  // Queue writes happen only on down accepts and reads only on up/destroy
  // cycles, so a read never meets a same-cycle write to the same entry.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    tail_d       = tail_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_tid_d    = out_tid_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_action)
            ACT_DOWN: begin
              out_valid_d = 1'b1;
              out_tid_d   = in_tid;
              out_last_d  = 1'b1;
              if (count_q < 16'sd1) begin
                if (total_q >= TotW'(MAX_WAITERS)) begin
                  out_status_d = ST_FULL;
                end else begin
                  count_d      = count_q - 16'sd1;
                  ram_we       = 1'b1;
                  tail_d       = ptr_next(tail_q);
                  total_d      = total_q + 1'b1;
                  out_status_d = ST_BLOCKED;
                end
              end else begin
                count_d      = count_q - 16'sd1;
                out_status_d = ST_GRANTED;
              end
            end
            ACT_UP: begin
              count_d = count_inc;
              if ((count_inc < 16'sd1) && (total_q != '0)) begin
                ram_re  = 1'b1;
                head_d  = ptr_next(head_q);
                total_d = total_q - 1'b1;
                state_d = S_WAKE;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = ST_NO_WAITER;
                out_tid_d    = '0;
                out_last_d   = 1'b1;
              end
            end
            ACT_DESTROY: begin
              if (total_q == '0) begin
                count_d = count_init;
                head_d  = '0;
                tail_d  = '0;
              end else begin
                ram_re  = 1'b1;
                head_d  = ptr_next(head_q);
                total_d = total_q - 1'b1;
                state_d = S_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_WAKE: begin
        // output register was emptied when the up request was taken
        out_valid_d  = 1'b1;
        out_status_d = ST_WOKEN;
        out_tid_d    = ram_rdata;
        out_last_d   = 1'b1;
        state_d      = S_IDLE;
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_RELEASED;
          out_tid_d    = ram_rdata;
          out_last_d   = (total_q == '0);
          if (total_q != '0) begin
            ram_re  = 1'b1;
            head_d  = ptr_next(head_q);
            total_d = total_q - 1'b1;
          end else begin
            count_d = count_init;
            head_d  = '0;
            tail_d  = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_GRANTED;
      out_tid_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_tid_q    <= out_tid_d;
      out_last_q   <= out_last_d;
    end
  end

  csfw_ram #(
    .WIDTH (TaskW),
    .DEPTH (MAX_WAITERS)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_tid),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - TaskW - 3){1'b0}}, out_tid_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[hw/rtl/csfw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/csfw_checker.sv]
// ----------------------------------------------------------------------------
// Semaphore checker
// Port-level assertions on the semaphore, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csfw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [csfw_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [csfw_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  import csfw_pkg::*;

  `ASSERT_DFLT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  `ASSERT_DFLT(a_status_range, m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(ST_FULL), "status out of range")

  `ASSERT_DFLT(a_no_waiter_id, m_axis_tvalid && (m_axis_tdata[2:0] == 3'(ST_NO_WAITER)) |-> m_axis_tdata[10:3] == 8'd0, "no-waiter result carries a task id")

  `ASSERT_DFLT(a_single_last, m_axis_tvalid && (m_axis_tdata[2:0] != 3'(ST_RELEASED)) |-> m_axis_tlast, "single result without tlast")

  `ASSERT_DFLT(a_down_result, s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == 2'(ACT_DOWN)) |=> m_axis_tvalid, "down request gave no result")

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (.*);
